[sv/ising_metropolis_spin_flip_defines.svh]
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip_defines
// Assertion macros for the spin-flip block.
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SPIN_FLIP_DEFINES_SVH
`define ISING_METROPOLIS_SPIN_FLIP_DEFINES_SVH

`ifndef SYNTHESIS
`define IMS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ims assertion failed");
`define IMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ims assertion failed");
`else
`define IMS_ASSERT_SAME(label, clk, rst, ante, cons)
`define IMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/ims_pkg.sv]
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types, constants and index helpers of the spin-flip block.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam int LATTICE_SIDE = 8;
  localparam int IDX_W        = (LATTICE_SIDE > 2) ? $clog2(LATTICE_SIDE) : 1;
  localparam int IN_IDX_W     = 3;
  localparam int WRAP_STEPS   = (1 << IN_IDX_W) / 2;
  localparam int KIND_W       = 2;
  localparam int RND_W        = 7;
  localparam int DELTA_W      = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  localparam logic [RND_W-1:0] RND_LIMIT = RND_W'(100);

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD = 2'd0,
    KIND_FLIP = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_FOUR  = 1'b0,
    CFG_RISE_EIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD2  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  typedef logic [LATTICE_SIDE-1:0] row_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  col;
    logic              spin_in;
    logic [RND_W-1:0]  rnd;
  } item_t;

  typedef struct packed {
    logic                      spin_out;
    logic                      accepted;
    logic signed [DELTA_W-1:0] energy_change;
  } result_t;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IN_IDX_W-1:0] v);
    logic [IN_IDX_W:0] t;
    t = {1'b0, v};
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (int'(t) >= LATTICE_SIDE) begin
        t = (IN_IDX_W + 1)'(int'(t) - LATTICE_SIDE);
      end
    end
    return IDX_W'(t);
  endfunction

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(LATTICE_SIDE - 1) : IDX_W'(i - 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(LATTICE_SIDE - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

endpackage

[sv/ims_ram.sv]
// ----------------------------------------------------------------------------
// ims_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module ims_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[sv/ims_eval.sv]
// ----------------------------------------------------------------------------
// ims_eval
// Energy change, Metropolis acceptance and row update for one item.
// ----------------------------------------------------------------------------
module ims_eval (
  input  ims_pkg::item_t           item,
  input  ims_pkg::row_t            site_row,
  input  ims_pkg::row_t            up_row,
  input  ims_pkg::row_t            down_row,
  input  logic [ims_pkg::RND_W-1:0] min_rnd_rise_four,
  input  logic [ims_pkg::RND_W-1:0] min_rnd_rise_eight,
  output ims_pkg::result_t         res,
  output ims_pkg::row_t            row_wr_data,
  output logic                     row_wr_en
);

  logic [ims_pkg::IDX_W-1:0]   col_l;
  logic [ims_pkg::IDX_W-1:0]   col_r;
  logic                        s;
  logic [2:0]                  n_plus;
  logic [ims_pkg::DELTA_W-1:0] n_times4;
  logic [ims_pkg::DELTA_W-1:0] delta;
  logic                        flip_ok;
  logic                        new_bit;

  assign col_l = ims_pkg::prev_idx(item.col);
  assign col_r = ims_pkg::next_idx(item.col);
  assign s     = site_row[item.col];

  assign n_plus = 3'(up_row[item.col]) + 3'(down_row[item.col])
                + 3'(site_row[col_l]) + 3'(site_row[col_r]);
  assign n_times4 = {n_plus, 2'b00};
  assign delta = s ? (ims_pkg::DELTA_W'(8) - n_times4) : (n_times4 - ims_pkg::DELTA_W'(8));

  always_comb begin
    if (delta[ims_pkg::DELTA_W-1] || delta == '0) begin
      flip_ok = 1'b1;
    end else if (delta == ims_pkg::DELTA_W'(4)) begin
      flip_ok = (min_rnd_rise_four < ims_pkg::RND_LIMIT) && (item.rnd >= min_rnd_rise_four);
    end else begin
      flip_ok = (min_rnd_rise_eight < ims_pkg::RND_LIMIT) && (item.rnd >= min_rnd_rise_eight);
    end
  end

  always_comb begin
    res = '0;
    row_wr_en = 1'b0;
    new_bit = s;
    case (ims_pkg::kind_t'(item.kind))
      ims_pkg::KIND_LOAD: begin
        new_bit = item.spin_in;
        row_wr_en = 1'b1;
      end
      ims_pkg::KIND_FLIP: begin
        new_bit = s ^ flip_ok;
        row_wr_en = flip_ok;
        res.accepted = flip_ok;
        res.energy_change = $signed(delta);
      end
      default: begin
        new_bit = s;
      end
    endcase
    res.spin_out = new_bit;
    for (int j = 0; j < ims_pkg::LATTICE_SIDE; j++) begin
      row_wr_data[j] = (ims_pkg::IDX_W'(j) == item.col) ? new_bit : site_row[j];
    end
  end

endmodule

[sv/ising_metropolis_spin_flip.sv]
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip
// Metropolis spin-flip engine on a periodic square lattice held in row RAM.
// ----------------------------------------------------------------------------
// The lattice sits in a RAM of one row per word with two read ports. In the
// accept cycle the block reads the site row and the row above, in the S_RD2
// state it reads the row below, and in the S_EXEC state it evaluates the item,
// registers the result and writes the updated row back. A new item is taken
// the cycle after the result is registered, so the block does not take a new
// item before the last one is through. The result waits in an output
// register; a stalled result holds the write-back stage. Sites hold no defined
// spin until loaded.
module ising_metropolis_spin_flip (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ims_pkg::KIND_W-1:0]         kind,
  input  logic [ims_pkg::IN_IDX_W-1:0]       row,
  input  logic [ims_pkg::IN_IDX_W-1:0]       col,
  input  logic                               spin_in,
  input  logic [ims_pkg::RND_W-1:0]          rnd,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               spin_out,
  output logic                               accepted,
  output logic signed [ims_pkg::DELTA_W-1:0] energy_change,
  input  logic                               cfg_we,
  input  logic [ims_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ims_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "ising_metropolis_spin_flip_defines.svh"

  ims_pkg::state_t            state;
  ims_pkg::state_t            state_next;
  ims_pkg::item_t             item;
  logic [ims_pkg::IDX_W-1:0]  row_q;
  ims_pkg::row_t              up_row;
  logic [ims_pkg::RND_W-1:0]  min_rnd_rise_four;
  logic [ims_pkg::RND_W-1:0]  min_rnd_rise_eight;
  logic [ims_pkg::IDX_W-1:0]  row_in;
  logic [ims_pkg::IDX_W-1:0]  rd_addr_a;
  logic [ims_pkg::IDX_W-1:0]  rd_addr_b;
  ims_pkg::row_t              rd_data_a;
  ims_pkg::row_t              rd_data_b;
  logic                       in_take;
  logic                       exec_go;
  ims_pkg::result_t           res;
  ims_pkg::row_t              row_wr_data;
  logic                       row_wr_en;
  logic                       mem_wr_en;

  assign in_stall = rst || (state != ims_pkg::S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign exec_go  = (state == ims_pkg::S_EXEC) && (!out_valid || !out_stall);
  assign row_in   = ims_pkg::wrap_idx(row);

  assign rd_addr_a = (state == ims_pkg::S_IDLE) ? row_in : row_q;
  assign rd_addr_b = (state == ims_pkg::S_IDLE) ? ims_pkg::prev_idx(row_in)
                                                 : ims_pkg::next_idx(row_q);
  assign mem_wr_en = exec_go && row_wr_en;

  ims_ram #(
    .WIDTH (ims_pkg::LATTICE_SIDE),
    .DEPTH (ims_pkg::LATTICE_SIDE)
  ) u_lattice (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (row_q),
    .wr_data   (row_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  ims_eval u_eval (
    .item               (item),
    .site_row           (rd_data_a),
    .up_row             (up_row),
    .down_row           (rd_data_b),
    .min_rnd_rise_four  (min_rnd_rise_four),
    .min_rnd_rise_eight (min_rnd_rise_eight),
    .res                (res),
    .row_wr_data        (row_wr_data),
    .row_wr_en          (row_wr_en)
  );

  always_comb begin
    state_next = state;
    case (state)
      ims_pkg::S_IDLE: if (in_take) state_next = ims_pkg::S_RD2;
      ims_pkg::S_RD2:  state_next = ims_pkg::S_EXEC;
      ims_pkg::S_EXEC: if (exec_go) state_next = ims_pkg::S_IDLE;
      default:         state_next = ims_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ims_pkg::S_IDLE;
      out_valid          <= 1'b0;
      min_rnd_rise_four  <= ims_pkg::RND_LIMIT;
      min_rnd_rise_eight <= ims_pkg::RND_LIMIT;
    end else begin
      state <= state_next;
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (ims_pkg::cfg_reg_t'(cfg_index))
          ims_pkg::CFG_RISE_FOUR:  min_rnd_rise_four  <= cfg_data;
          ims_pkg::CFG_RISE_EIGHT: min_rnd_rise_eight <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.kind    <= kind;
      item.col     <= ims_pkg::wrap_idx(col);
      item.spin_in <= spin_in;
      item.rnd     <= rnd;
      row_q        <= row_in;
    end
    if (state == ims_pkg::S_RD2) begin
      up_row <= rd_data_b;
    end
    if (exec_go) begin
      spin_out      <= res.spin_out;
      accepted      <= res.accepted;
      energy_change <= res.energy_change;
    end
  end

  `IMS_ASSERT_NEXT(a_take_reads, clk, rst, in_take, state == ims_pkg::S_RD2)
  `IMS_ASSERT_SAME(a_write_in_exec, clk, rst, mem_wr_en, state == ims_pkg::S_EXEC)
  `IMS_ASSERT_SAME(a_delta_step, clk, rst, out_valid, energy_change[1:0] == 2'b00)
  `IMS_ASSERT_SAME(a_accept_rise, clk, rst, out_valid && accepted, energy_change <= 0 || energy_change == 4 || energy_change == 8)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Metropolis spin-flip block on an 8x8 lattice.
// ----------------------------------------------------------------------------
// Fills the lattice, walks a short table of directed items, then runs phases
// of random load, flip, read and spare items under different thresholds,
// idle and stall patterns. Each accepted item updates a local copy of the
// lattice and pushes the expected result; every result is checked in order.
module testbench;

  localparam logic [ims_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 228;
  localparam int HOLDOFF_CYCLES  = 200;
  localparam int SETTLE_CYCLES   = 10;
  localparam int DRAIN_LIMIT     = 50000;

  typedef struct {
    logic [ims_pkg::KIND_W-1:0]   kind;
    logic [ims_pkg::IN_IDX_W-1:0] row;
    logic [ims_pkg::IN_IDX_W-1:0] col;
    logic                         spin;
    logic [ims_pkg::RND_W-1:0]    rnd;
    bit                           typed;
    logic                         spin_x;
    logic                         acc_x;
    int                           delta_x;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [ims_pkg::KIND_W-1:0]         kind = '0;
  logic [ims_pkg::IN_IDX_W-1:0]       row = '0;
  logic [ims_pkg::IN_IDX_W-1:0]       col = '0;
  logic                               spin_in = 1'b0;
  logic [ims_pkg::RND_W-1:0]          rnd = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic                               spin_out;
  logic                               accepted;
  logic signed [ims_pkg::DELTA_W-1:0] energy_change;
  logic                               cfg_we = 1'b0;
  logic [ims_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [ims_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  bit                        site_spin [ims_pkg::LATTICE_SIDE][ims_pkg::LATTICE_SIDE];
  logic [ims_pkg::RND_W-1:0] rise_four_min = ims_pkg::RND_LIMIT;
  logic [ims_pkg::RND_W-1:0] rise_eight_min = ims_pkg::RND_LIMIT;
  ims_pkg::result_t          pending_results [$];
  ims_pkg::result_t          spin_want;
  int                        err_count = 0;
  int                        send_idle_pct = 0;
  int                        recv_stall_pct = 0;
  logic                      holdoff_start = 1'b0;
  logic                      holding = 1'b0;

  stim_row_t directed_rows [18] = '{
    '{ims_pkg::KIND_READ, 3'd0, 3'd0, 1'b0, 7'd0,   1'b1, 1'b1, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd0, 3'd0, 1'b0, 7'd0,   1'b1, 1'b0, 1'b1, -8},
    '{ims_pkg::KIND_FLIP, 3'd0, 3'd0, 1'b0, 7'd127, 1'b1, 1'b0, 1'b0, 8},
    '{KIND_SPARE,         3'd0, 3'd0, 1'b0, 7'd0,   1'b1, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_LOAD, 3'd1, 3'd2, 1'b0, 7'd0,   1'b1, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_LOAD, 3'd3, 3'd2, 1'b0, 7'd0,   1'b1, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_LOAD, 3'd2, 3'd1, 1'b0, 7'd0,   1'b1, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd2, 3'd2, 1'b0, 7'd99,  1'b1, 1'b1, 1'b0, 4},
    '{ims_pkg::KIND_LOAD, 3'd7, 3'd7, 1'b0, 7'd0,   1'b1, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd7, 3'd7, 1'b1, 7'd0,   1'b1, 1'b0, 1'b0, 8},
    '{ims_pkg::KIND_FLIP, 3'd0, 3'd7, 1'b0, 7'd50,  1'b0, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd2, 3'd3, 1'b0, 7'd127, 1'b0, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd1, 3'd1, 1'b0, 7'd0,   1'b0, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_READ, 3'd7, 3'd0, 1'b1, 7'd64,  1'b0, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_LOAD, 3'd5, 3'd5, 1'b1, 7'd0,   1'b0, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd3, 3'd2, 1'b0, 7'd127, 1'b0, 1'b0, 1'b0, 0},
    '{KIND_SPARE,         3'd2, 3'd2, 1'b1, 7'd99,  1'b0, 1'b0, 1'b0, 0},
    '{ims_pkg::KIND_FLIP, 3'd2, 3'd1, 1'b1, 7'd99,  1'b0, 1'b0, 1'b0, 0}
  };

  ising_metropolis_spin_flip uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .row           (row),
    .col           (col),
    .spin_in       (spin_in),
    .rnd           (rnd),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .spin_out      (spin_out),
    .accepted      (accepted),
    .energy_change (energy_change),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int spin_sign(bit b);
    return b ? 1 : -1;
  endfunction

  function automatic ims_pkg::result_t metropolis_step(
      logic [ims_pkg::KIND_W-1:0] k, logic [ims_pkg::IN_IDX_W-1:0] r,
      logic [ims_pkg::IN_IDX_W-1:0] c, logic s_in, logic [ims_pkg::RND_W-1:0] rv);
    ims_pkg::result_t res;
    int               ri, ci, nsum, dl;
    logic             take;
    ri = int'(r) % ims_pkg::LATTICE_SIDE;
    ci = int'(c) % ims_pkg::LATTICE_SIDE;
    dl = 0;
    take = 1'b0;
    case (k)
      ims_pkg::KIND_LOAD: site_spin[ri][ci] = s_in;
      ims_pkg::KIND_FLIP: begin
        nsum = spin_sign(site_spin[(ri + ims_pkg::LATTICE_SIDE - 1) % ims_pkg::LATTICE_SIDE][ci])
             + spin_sign(site_spin[(ri + 1) % ims_pkg::LATTICE_SIDE][ci])
             + spin_sign(site_spin[ri][(ci + ims_pkg::LATTICE_SIDE - 1) % ims_pkg::LATTICE_SIDE])
             + spin_sign(site_spin[ri][(ci + 1) % ims_pkg::LATTICE_SIDE]);
        dl = -2 * spin_sign(site_spin[ri][ci]) * nsum;
        if (dl <= 0) begin
          take = 1'b1;
        end else if (dl == 4) begin
          take = (rise_four_min < ims_pkg::RND_LIMIT) && (rv >= rise_four_min);
        end else begin
          take = (rise_eight_min < ims_pkg::RND_LIMIT) && (rv >= rise_eight_min);
        end
        if (take) begin
          site_spin[ri][ci] = ~site_spin[ri][ci];
        end
      end
      default: ;
    endcase
    res.spin_out = site_spin[ri][ci];
    res.accepted = take;
    res.energy_change = ims_pkg::DELTA_W'(dl);
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // offer one item, hold it until taken, then record its expected result
  task automatic push_item(logic [ims_pkg::KIND_W-1:0] k, logic [ims_pkg::IN_IDX_W-1:0] r,
                           logic [ims_pkg::IN_IDX_W-1:0] c, logic s_in,
                           logic [ims_pkg::RND_W-1:0] rv,
                           bit use_typed, ims_pkg::result_t typed_res);
    ims_pkg::result_t pred;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    row <= r;
    col <= c;
    spin_in <= s_in;
    rnd <= rv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = metropolis_step(k, r, c, s_in, rv);
    pending_results.push_back(use_typed ? typed_res : pred);
  endtask

  task automatic push_random_item();
    int                         pick;
    logic [ims_pkg::KIND_W-1:0] k;
    logic [ims_pkg::RND_W-1:0]  rv;
    pick = $urandom_range(0, 99);
    if (pick < 25) k = ims_pkg::KIND_LOAD;
    else if (pick < 80) k = ims_pkg::KIND_FLIP;
    else if (pick < 95) k = ims_pkg::KIND_READ;
    else k = KIND_SPARE;
    if ($urandom_range(0, 99) < 85) rv = ims_pkg::RND_W'($urandom_range(0, 99));
    else rv = ims_pkg::RND_W'($urandom_range(100, 127));
    push_item(k, ims_pkg::IN_IDX_W'($urandom_range(0, 7)),
              ims_pkg::IN_IDX_W'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)), rv, 1'b0, '0);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [ims_pkg::RND_W-1:0] four,
                                  logic [ims_pkg::RND_W-1:0] eight);
    cfg_we <= 1'b1;
    cfg_index <= ims_pkg::CFG_RISE_FOUR;
    cfg_data <= four;
    @(posedge clk);
    cfg_index <= ims_pkg::CFG_RISE_EIGHT;
    cfg_data <= eight;
    @(posedge clk);
    cfg_we <= 1'b0;
    rise_four_min = four;
    rise_eight_min = eight;
  endtask

  always @(posedge clk) begin
    out_stall <= holding || ($urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin : holdoff_proc
    forever begin
      @(posedge clk);
      if (holdoff_start) begin
        holdoff_start <= 1'b0;
        holding <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holding <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing expected");
      end else begin
        spin_want = pending_results.pop_front();
        if (spin_out !== spin_want.spin_out)
          flag_mismatch($sformatf("spin_out %b, want %b", spin_out, spin_want.spin_out));
        if (accepted !== spin_want.accepted)
          flag_mismatch($sformatf("accepted %b, want %b", accepted, spin_want.accepted));
        if (energy_change !== spin_want.energy_change)
          flag_mismatch($sformatf("energy_change %0d, want %0d", energy_change,
                                  spin_want.energy_change));
      end
    end
  end

  initial begin : stimulus
    int                        r, c, ph, n;
    ims_pkg::result_t          typed_res;
    logic [ims_pkg::RND_W-1:0] four_list [NUM_PHASES];
    logic [ims_pkg::RND_W-1:0] eight_list [NUM_PHASES];
    int                        idle_list [4];
    int                        stall_list [4];
    four_list  = '{7'd0, 7'd50, 7'd100, 7'd99, 7'd127, 7'd25};
    eight_list = '{7'd0, 7'd100, 7'd0, 7'd30, 7'd1, 7'd75};
    idle_list  = '{0, 88, 0, 30};
    stall_list = '{0, 0, 88, 30};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (r = 0; r < ims_pkg::LATTICE_SIDE; r++) begin
      for (c = 0; c < ims_pkg::LATTICE_SIDE; c++) begin
        push_item(ims_pkg::KIND_LOAD, ims_pkg::IN_IDX_W'(r), ims_pkg::IN_IDX_W'(c), 1'b1,
                  ims_pkg::RND_W'($urandom_range(0, 127)), 1'b0, '0);
      end
    end
    foreach (directed_rows[i]) begin
      typed_res.spin_out = directed_rows[i].spin_x;
      typed_res.accepted = directed_rows[i].acc_x;
      typed_res.energy_change = ims_pkg::DELTA_W'(directed_rows[i].delta_x);
      push_item(directed_rows[i].kind, directed_rows[i].row, directed_rows[i].col,
                directed_rows[i].spin, directed_rows[i].rnd, directed_rows[i].typed,
                typed_res);
    end
    drain_results();
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_thresholds(four_list[ph], eight_list[ph]);
      send_idle_pct = idle_list[ph % 4];
      recv_stall_pct = stall_list[ph % 4];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 60) holdoff_start <= 1'b1;
        if (ph == 1 && n == 120) drain_results();
        push_random_item();
      end
      drain_results();
    end
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never came", pending_results.size()));
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
